/* rtl/hhfp_pkg.sv */
// Shared codes, limits and helper functions of the HTTP header field parser.
package hhfp_pkg;

  // Size limits of one header block
  localparam logic [15:0] BUFFER_BYTES      = 16'd4096;
  localparam logic [7:0]  MAX_EXTRA_HEADERS = 8'd32;
  localparam logic [7:0]  EXTRA_COUNT_MAX   = 8'd255;

  // Configuration register indexes
  localparam logic CFG_HASH_SEED    = 1'b0;
  localparam logic CFG_START_OFFSET = 1'b1;

  // Event codes
  localparam logic [2:0] EV_NONE  = 3'd0;
  localparam logic [2:0] EV_KEY   = 3'd1;
  localparam logic [2:0] EV_VALUE = 3'd2;
  localparam logic [2:0] EV_DONE  = 3'd3;
  localparam logic [2:0] EV_ERR   = 3'd4;

  // Error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_BAD_BYTE   = 3'd1;
  localparam logic [2:0] ERR_TOO_LARGE  = 3'd2;
  localparam logic [2:0] ERR_DUPLICATE  = 3'd3;
  localparam logic [2:0] ERR_EMPTY_HOST = 3'd4;

  // Known header ids
  localparam logic [2:0] HDR_UNKNOWN = 3'd0;
  localparam logic [2:0] HDR_HOST    = 3'd1;
  localparam logic [2:0] HDR_CLEN    = 3'd2;
  localparam logic [2:0] HDR_TE      = 3'd3;
  localparam logic [2:0] HDR_CTYPE   = 3'd4;
  localparam logic [2:0] HDR_CONN    = 3'd5;
  localparam logic [2:0] HDR_COOKIE  = 3'd6;

  // Hash constants
  localparam logic [31:0] HASH_MUL         = 32'h5bd1e995;
  localparam logic [31:0] HASH_HOST        = 32'h1e5aeec4;
  localparam logic [31:0] HASH_CLEN        = 32'h240bbc50;
  localparam logic [31:0] HASH_TE          = 32'h41141d0c;
  localparam logic [31:0] HASH_CTYPE       = 32'hc947e5d0;
  localparam logic [31:0] HASH_CONN        = 32'h8fd8a976;
  localparam logic [31:0] HASH_COOKIE      = 32'h4def559a;

  // Characters
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_TILDE = 8'h7e;

  function automatic logic is_token(input logic [7:0] c);
    logic tok;
    tok = ((c >= 8'h30) && (c <= 8'h39)) ||
          ((c >= 8'h61) && (c <= 8'h7a)) ||
          ((c >= 8'h41) && (c <= 8'h5a));
    unique case (c)
      8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2a, 8'h2b,
      8'h2d, 8'h2e, 8'h5e, 8'h5f, 8'h60, 8'h7c, 8'h7e: tok = 1'b1;
      default: ;
    endcase
    return tok;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if ((c >= 8'h41) && (c <= 8'h5a)) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  // One round: xor the byte, multiply, xor-shift by 15
  function automatic logic [31:0] hash_round(input logic [31:0] h, input logic [7:0] c);
    logic [31:0] x;
    logic [31:0] m;
    x = h ^ {24'd0, c};
    m = x * HASH_MUL;
    return m ^ (m >> 15);
  endfunction

  function automatic logic [2:0] header_of(input logic [31:0] h);
    logic [2:0] id;
    unique case (h)
      HASH_HOST:   id = HDR_HOST;
      HASH_CLEN:   id = HDR_CLEN;
      HASH_TE:     id = HDR_TE;
      HASH_CTYPE:  id = HDR_CTYPE;
      HASH_CONN:   id = HDR_CONN;
      HASH_COOKIE: id = HDR_COOKIE;
      default:     id = HDR_UNKNOWN;
    endcase
    return id;
  endfunction

endpackage

/* rtl/http_header_field_parser.sv */
// HTTP header field parser: one header-block byte in, one event item out per byte.
//
// The parser takes one byte item per cycle while the output side is not stalled
// and returns exactly one result item per byte. The result item is held in the
// result register until the output side takes it.
// A byte passes an input register, then one pass of logic updates the parse
// state and loads the result register; the rate of one byte per cycle is set by
// the key hash loop, which runs one round (a 32x32 multiply and an xor-shift) per
// cycle. Key bytes are checked as token characters and hashed lower-cased; at the
// colon the hash picks one of six known headers and a key event gives position
// and length. Leading blanks of a value are skipped, trailing blanks trimmed, and
// a value event at CR gives the trimmed extent. Lines end in CR LF and an empty
// line ends the block. After an error or a finished block the parser halts and
// answers every byte with an empty event at a frozen position until an item with
// restart set. Write hash_seed and start_offset only while no item is in flight.
module http_header_field_parser #(
  parameter logic [15:0] BUFFER_BYTES      = hhfp_pkg::BUFFER_BYTES,
  parameter logic [7:0]  MAX_EXTRA_HEADERS = hhfp_pkg::MAX_EXTRA_HEADERS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // byte items
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        restart_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  event_res_o,
  output logic [2:0]  error_code_o,
  output logic [2:0]  header_id_o,
  output logic [31:0] key_hash_o,
  output logic [15:0] field_start_o,
  output logic [15:0] field_len_o,
  output logic [15:0] position_o
);

  typedef enum logic [1:0] {
    PH_KEY,
    PH_VALUE,
    PH_LF,
    PH_DECIDE
  } phase_e;

  // Configuration registers
  logic [31:0] hash_seed_q;
  logic [15:0] start_offset_q;

  // Input register
  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;
  logic        s1_restart_q;
  logic        s1_fire;

  // Parse state
  phase_e      phase_q, phase_d;
  logic [15:0] pos_q, pos_d;
  logic [15:0] key_begin_q, key_begin_d;
  logic [15:0] value_begin_q, value_begin_d;
  logic [15:0] trim_end_q, trim_end_d;
  logic [31:0] hash_q, hash_d;
  logic [2:0]  cur_hdr_q, cur_hdr_d;
  logic        skip_q, skip_d;
  logic        empty_q, empty_d;
  logic [7:0]  extra_cnt_q, extra_cnt_d;
  logic        host_q, host_d;
  logic        clen_q, clen_d;
  logic        halted_q, halted_d;
  logic [3:0]  other_q, other_d;
  logic        val_extra_q, val_extra_d;

  // Result register
  logic        out_valid_q;
  logic [2:0]  ev_q, ev_d;
  logic [2:0]  err_q, err_d;
  logic [2:0]  hid_q, hid_d;
  logic [31:0] khash_q, khash_d;
  logic [15:0] fstart_q, fstart_d;
  logic [15:0] flen_q, flen_d;
  logic [15:0] opos_q, opos_d;

  assign cfg_ready_o = 1'b1;

  // Advance the input stage whenever the result register is free or drains now
  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;

  always_comb begin
    logic [7:0]  c;
    logic [7:0]  lc;
    logic        fail;
    logic [2:0]  fail_code;
    logic        do_key;
    logic [15:0] kb;
    logic [31:0] h;
    logic [2:0]  id;
    logic [2:0]  id_off;
    logic        extra;
    logic [15:0] vb;
    logic [15:0] te;
    logic [15:0] len;
    logic [15:0] pos_inc;

    c = s1_byte_q;
    lc = hhfp_pkg::to_lower(c);
    fail = 1'b0;
    fail_code = hhfp_pkg::ERR_NONE;

    // Restart reloads the whole parse state before this byte is handled
    if (s1_restart_q) begin
      phase_d       = PH_KEY;
      pos_d         = start_offset_q;
      key_begin_d   = start_offset_q;
      value_begin_d = start_offset_q;
      trim_end_d    = start_offset_q;
      hash_d        = hash_seed_q;
      cur_hdr_d     = hhfp_pkg::HDR_UNKNOWN;
      skip_d        = 1'b0;
      empty_d       = 1'b0;
      extra_cnt_d   = '0;
      host_d        = 1'b0;
      clen_d        = 1'b0;
      halted_d      = 1'b0;
      other_d       = '0;
      val_extra_d   = 1'b0;
    end else begin
      phase_d       = phase_q;
      pos_d         = pos_q;
      key_begin_d   = key_begin_q;
      value_begin_d = value_begin_q;
      trim_end_d    = trim_end_q;
      hash_d        = hash_q;
      cur_hdr_d     = cur_hdr_q;
      skip_d        = skip_q;
      empty_d       = empty_q;
      extra_cnt_d   = extra_cnt_q;
      host_d        = host_q;
      clen_d        = clen_q;
      halted_d      = halted_q;
      other_d       = other_q;
      val_extra_d   = val_extra_q;
    end

    pos_inc  = pos_d + 16'd1;
    ev_d     = hhfp_pkg::EV_NONE;
    err_d    = hhfp_pkg::ERR_NONE;
    hid_d    = hhfp_pkg::HDR_UNKNOWN;
    khash_d  = '0;
    fstart_d = '0;
    flen_d   = '0;
    opos_d   = pos_d;

    do_key = 1'b0;
    kb     = key_begin_d;
    h      = hash_d;
    id     = hhfp_pkg::header_of(h);
    id_off = id - hhfp_pkg::HDR_TE;
    extra  = 1'b0;
    vb     = value_begin_d;
    te     = trim_end_d;
    len    = '0;

    if (halted_d) begin
      // hold everything; empty event at the frozen position
    end else if (pos_d >= BUFFER_BYTES) begin
      fail = 1'b1;
      fail_code = hhfp_pkg::ERR_TOO_LARGE;
    end else begin
      unique case (phase_d)
        PH_LF: begin
          if (c != hhfp_pkg::CH_LF) begin
            fail = 1'b1;
            fail_code = hhfp_pkg::ERR_BAD_BYTE;
          end else begin
            pos_d = pos_inc;
            if (empty_d) begin
              halted_d = 1'b1;
              ev_d = hhfp_pkg::EV_DONE;
            end else begin
              phase_d = PH_DECIDE;
            end
          end
        end
        PH_DECIDE: begin
          if (c == hhfp_pkg::CH_CR) begin
            empty_d = 1'b1;
            phase_d = PH_LF;
            pos_d = pos_inc;
          end else begin
            // a new key starts at this byte
            empty_d     = 1'b0;
            kb          = pos_d;
            key_begin_d = pos_d;
            h           = hash_seed_q;
            cur_hdr_d   = hhfp_pkg::HDR_UNKNOWN;
            phase_d     = PH_KEY;
            do_key      = 1'b1;
          end
        end
        PH_KEY: begin
          do_key = 1'b1;
        end
        PH_VALUE: begin
          if (skip_d && ((c == hhfp_pkg::CH_SPACE) || (c == hhfp_pkg::CH_TAB))) begin
            pos_d = pos_inc;
          end else begin
            if (skip_d) begin
              vb     = pos_d;
              te     = pos_d;
              skip_d = 1'b0;
            end
            value_begin_d = vb;
            trim_end_d    = te;
            len           = te - vb;
            if (c == hhfp_pkg::CH_CR) begin
              if ((cur_hdr_d == hhfp_pkg::HDR_HOST) && (len == 16'd0)) begin
                fail = 1'b1;
                fail_code = hhfp_pkg::ERR_EMPTY_HOST;
              end else begin
                if (val_extra_d && (extra_cnt_d < hhfp_pkg::EXTRA_COUNT_MAX)) begin
                  extra_cnt_d = extra_cnt_d + 8'd1;
                end
                ev_d     = hhfp_pkg::EV_VALUE;
                hid_d    = cur_hdr_d;
                fstart_d = vb;
                flen_d   = len;
                phase_d  = PH_LF;
                pos_d    = pos_inc;
              end
            end else if ((c < hhfp_pkg::CH_SPACE) || (c > hhfp_pkg::CH_TILDE)) begin
              fail = 1'b1;
              fail_code = hhfp_pkg::ERR_BAD_BYTE;
            end else begin
              if (c != hhfp_pkg::CH_SPACE) begin
                trim_end_d = pos_inc;
              end
              pos_d = pos_inc;
            end
          end
        end
        default: ;
      endcase

      // Key byte handling, also reached from the line-start decision
      if (do_key) begin
        id     = hhfp_pkg::header_of(h);
        id_off = id - hhfp_pkg::HDR_TE;
        if (extra_cnt_d >= MAX_EXTRA_HEADERS) begin
          fail = 1'b1;
          fail_code = hhfp_pkg::ERR_TOO_LARGE;
        end else if (c == hhfp_pkg::CH_COLON) begin
          if (id == hhfp_pkg::HDR_HOST) begin
            if (host_d) begin
              fail = 1'b1;
              fail_code = hhfp_pkg::ERR_DUPLICATE;
            end
            host_d = 1'b1;
          end else if (id == hhfp_pkg::HDR_CLEN) begin
            if (clen_d) begin
              fail = 1'b1;
              fail_code = hhfp_pkg::ERR_DUPLICATE;
            end
            clen_d = 1'b1;
          end else if (id >= hhfp_pkg::HDR_TE) begin
            extra = other_d[id_off[1:0]];
            other_d[id_off[1:0]] = 1'b1;
          end else begin
            extra = 1'b1;
          end
          if (!fail) begin
            ev_d        = hhfp_pkg::EV_KEY;
            hid_d       = id;
            khash_d     = h;
            fstart_d    = kb;
            flen_d      = pos_d - kb;
            cur_hdr_d   = id;
            val_extra_d = extra;
            hash_d      = hash_seed_q;
            skip_d      = 1'b1;
            phase_d     = PH_VALUE;
            pos_d       = pos_inc;
          end
        end else if (!hhfp_pkg::is_token(c)) begin
          fail = 1'b1;
          fail_code = hhfp_pkg::ERR_BAD_BYTE;
        end else begin
          hash_d = hhfp_pkg::hash_round(h, lc);
          pos_d  = pos_inc;
        end
      end
    end

    // Errors halt the parser and report only the code and position
    if (fail) begin
      halted_d = 1'b1;
      ev_d     = hhfp_pkg::EV_ERR;
      err_d    = fail_code;
      hid_d    = hhfp_pkg::HDR_UNKNOWN;
      khash_d  = '0;
      fstart_d = '0;
      flen_d   = '0;
    end
  end

  // Configuration, input register, parse state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_seed_q    <= '0;
      start_offset_q <= '0;
      s1_valid_q     <= 1'b0;
      s1_byte_q      <= '0;
      s1_restart_q   <= 1'b0;
      out_valid_q    <= 1'b0;
      phase_q        <= PH_KEY;
      pos_q          <= '0;
      key_begin_q    <= '0;
      value_begin_q  <= '0;
      trim_end_q     <= '0;
      hash_q         <= '0;
      cur_hdr_q      <= hhfp_pkg::HDR_UNKNOWN;
      skip_q         <= 1'b0;
      empty_q        <= 1'b0;
      extra_cnt_q    <= '0;
      host_q         <= 1'b0;
      clen_q         <= 1'b0;
      halted_q       <= 1'b0;
      other_q        <= '0;
      val_extra_q    <= 1'b0;
      ev_q           <= hhfp_pkg::EV_NONE;
      err_q          <= hhfp_pkg::ERR_NONE;
      hid_q          <= hhfp_pkg::HDR_UNKNOWN;
      khash_q        <= '0;
      fstart_q       <= '0;
      flen_q         <= '0;
      opos_q         <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          hhfp_pkg::CFG_HASH_SEED:    hash_seed_q    <= cfg_data_i;
          hhfp_pkg::CFG_START_OFFSET: start_offset_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      // input register: load on acceptance, drop when passed on
      if (in_valid_i && in_ready_o) begin
        s1_valid_q   <= 1'b1;
        s1_byte_q    <= data_byte_i;
        s1_restart_q <= restart_i;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      // result register
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        phase_q       <= phase_d;
        pos_q         <= pos_d;
        key_begin_q   <= key_begin_d;
        value_begin_q <= value_begin_d;
        trim_end_q    <= trim_end_d;
        hash_q        <= hash_d;
        cur_hdr_q     <= cur_hdr_d;
        skip_q        <= skip_d;
        empty_q       <= empty_d;
        extra_cnt_q   <= extra_cnt_d;
        host_q        <= host_d;
        clen_q        <= clen_d;
        halted_q      <= halted_d;
        other_q       <= other_d;
        val_extra_q   <= val_extra_d;
        ev_q          <= ev_d;
        err_q         <= err_d;
        hid_q         <= hid_d;
        khash_q       <= khash_d;
        fstart_q      <= fstart_d;
        flen_q        <= flen_d;
        opos_q        <= opos_d;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_res_o   = ev_q;
  assign error_code_o  = err_q;
  assign header_id_o   = hid_q;
  assign key_hash_o    = khash_q;
  assign field_start_o = fstart_q;
  assign field_len_o   = flen_q;
  assign position_o    = opos_q;

  // A halted parser answers with an empty event unless restarted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && halted_q && !s1_restart_q |=> out_valid_q && (ev_q == hhfp_pkg::EV_NONE))
    else $error("halted parser produced an event");

  // An error code is given exactly with an error event
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((ev_q == hhfp_pkg::EV_ERR) == (err_q != hhfp_pkg::ERR_NONE)))
    else $error("error code and event disagree");

  // Without restart the position holds or advances by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && !s1_restart_q |=>
      (pos_q == $past(pos_q)) || (pos_q == $past(pos_q) + 16'd1))
    else $error("position jumped");

  // Block completion only comes from the line-feed phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && (phase_q != PH_LF) |=> ev_q != hhfp_pkg::EV_DONE)
    else $error("block completed outside line-feed phase");

endmodule

/* sim/http_header_field_parser_tb.sv */
// Self-checking testbench of the HTTP header field parser: directed table, then random requests.
module http_header_field_parser_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int REPORT_MAX  = 10;

  // Parser phases as the predictor tracks them
  typedef enum logic [2:0] {
    PH_KEY    = 3'd0,
    PH_VALUE  = 3'd1,
    PH_LF     = 3'd2,
    PH_DECIDE = 3'd3
  } parse_phase_e;

  typedef struct packed {
    logic [2:0]  ev;
    logic [2:0]  err;
    logic [2:0]  hdr;
    logic [31:0] hash;
    logic [15:0] fstart;
    logic [15:0] flen;
    logic [15:0] pos;
  } parse_result_t;

  // One row of the directed table; typed rows carry their result, others go to the predictor
  typedef struct packed {
    logic [7:0]  data;
    logic        restart;
    logic        typed;
    logic [2:0]  ev;
    logic [2:0]  err;
    logic [15:0] pos;
  } directed_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = '0;
  logic        restart_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  event_res_o;
  logic [2:0]  error_code_o;
  logic [2:0]  header_id_o;
  logic [31:0] key_hash_o;
  logic [15:0] field_start_o;
  logic [15:0] field_len_o;
  logic [15:0] position_o;

  http_header_field_parser DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .restart_i     (restart_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .event_res_o   (event_res_o),
    .error_code_o  (error_code_o),
    .header_id_o   (header_id_o),
    .key_hash_o    (key_hash_o),
    .field_start_o (field_start_o),
    .field_len_o   (field_len_o),
    .position_o    (position_o)
  );

  always #10 clk_i = ~clk_i;

  // Register copies as the block should hold them
  logic [31:0] seed_reg = '0;
  logic [15:0] offset_reg = '0;

  // Predicted parser state
  parse_phase_e st_phase;
  logic [15:0]  st_pos, st_key_begin, st_value_begin, st_trim_end;
  logic [31:0]  st_hash;
  logic [2:0]   st_header;
  logic         st_skip, st_empty_line, st_host_seen, st_length_seen, st_halted;
  logic [7:0]   st_extras;
  logic [3:0]   st_other_seen;
  logic         st_value_extra;

  parse_result_t expected_events [$];
  logic [7:0]    request_bytes [$];
  int            items_sent = 0;
  int            mismatch_count = 0;
  int            cycle_count = 0;
  logic          steady = 1'b0;

  logic [7:0] key_symbols [15] = '{8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2a, 8'h2b,
                                   8'h2d, 8'h2e, 8'h5e, 8'h5f, 8'h60, 8'h7c, 8'h7e};
  string header_names [6] = '{"host", "content-length", "transfer-encoding",
                              "content-type", "connection", "cookie"};

  // Directed table, walked from reset values: seed 0, offset 0
  directed_row_t directed_rows [28] = '{
    // CR as first byte
    '{hhfp_pkg::CH_CR, 1'b1, 1'b1, hhfp_pkg::EV_ERR, hhfp_pkg::ERR_BAD_BYTE, 16'd0},
    // halted, frozen position
    '{"a", 1'b0, 1'b1, hhfp_pkg::EV_NONE, hhfp_pkg::ERR_NONE, 16'd0},
    // upper-case key byte
    '{"X", 1'b1, 1'b1, hhfp_pkg::EV_NONE, hhfp_pkg::ERR_NONE, 16'd0},
    '{hhfp_pkg::CH_TILDE, 1'b0, 1'b1, hhfp_pkg::EV_NONE, hhfp_pkg::ERR_NONE, 16'd1},
    '{hhfp_pkg::CH_COLON, 1'b0, 1'b0, hhfp_pkg::EV_NONE, hhfp_pkg::ERR_NONE, 16'd0},
    // leading tab skipped
    '{hhfp_pkg::CH_TAB, 1'b0, 1'b1, hhfp_pkg::EV_NONE, hhfp_pkg::ERR_NONE, 16'd3},
    '{hhfp_pkg::CH_SPACE, 1'b0, 1'b1, hhfp_pkg::EV_NONE, hhfp_pkg::ERR_NONE, 16'd4},
    '{"v", 1'b0, 1'b1, hhfp_pkg::EV_NONE, hhfp_pkg::ERR_NONE, 16'd5},
    // trailing blank
    '{hhfp_pkg::CH_SPACE, 1'b0, 1'b1, hhfp_pkg::EV_NONE, hhfp_pkg::ERR_NONE, 16'd6},
    '{hhfp_pkg::CH_CR, 1'b0, 1'b0, hhfp_pkg::EV_NONE, hhfp_pkg::ERR_NONE, 16'd0},
    '{hhfp_pkg::CH_LF, 1'b0, 1'b1, hhfp_pkg::EV_NONE, hhfp_pkg::ERR_NONE, 16'd8},
    // empty key
    '{hhfp_pkg::CH_COLON, 1'b0, 1'b0, hhfp_pkg::EV_NONE, hhfp_pkg::ERR_NONE, 16'd0},
    '{hhfp_pkg::CH_SPACE, 1'b0, 1'b1, hhfp_pkg::EV_NONE, hhfp_pkg::ERR_NONE, 16'd10},
    // blank value
    '{hhfp_pkg::CH_CR, 1'b0, 1'b0, hhfp_pkg::EV_NONE, hhfp_pkg::ERR_NONE, 16'd0},
    '{hhfp_pkg::CH_LF, 1'b0, 1'b1, hhfp_pkg::EV_NONE, hhfp_pkg::ERR_NONE, 16'd12},
    '{"a", 1'b0, 1'b1, hhfp_pkg::EV_NONE, hhfp_pkg::ERR_NONE, 16'd13},
    '{hhfp_pkg::CH_COLON, 1'b0, 1'b0, hhfp_pkg::EV_NONE, hhfp_pkg::ERR_NONE, 16'd0},
    // top byte in value
    '{8'hff, 1'b0, 1'b1, hhfp_pkg::EV_ERR, hhfp_pkg::ERR_BAD_BYTE, 16'd15},
    // zero byte in key
    '{8'h00, 1'b1, 1'b1, hhfp_pkg::EV_ERR, hhfp_pkg::ERR_BAD_BYTE, 16'd0},
    '{hhfp_pkg::CH_COLON, 1'b1, 1'b0, hhfp_pkg::EV_NONE, hhfp_pkg::ERR_NONE, 16'd0},
    '{"x", 1'b0, 1'b1, hhfp_pkg::EV_NONE, hhfp_pkg::ERR_NONE, 16'd1},
    // tab inside value
    '{hhfp_pkg::CH_TAB, 1'b0, 1'b1, hhfp_pkg::EV_ERR, hhfp_pkg::ERR_BAD_BYTE, 16'd2},
    '{hhfp_pkg::CH_COLON, 1'b1, 1'b0, hhfp_pkg::EV_NONE, hhfp_pkg::ERR_NONE, 16'd0},
    '{hhfp_pkg::CH_CR, 1'b0, 1'b0, hhfp_pkg::EV_NONE, hhfp_pkg::ERR_NONE, 16'd0},
    '{hhfp_pkg::CH_LF, 1'b0, 1'b1, hhfp_pkg::EV_NONE, hhfp_pkg::ERR_NONE, 16'd2},
    // empty line
    '{hhfp_pkg::CH_CR, 1'b0, 1'b1, hhfp_pkg::EV_NONE, hhfp_pkg::ERR_NONE, 16'd3},
    '{hhfp_pkg::CH_LF, 1'b0, 1'b1, hhfp_pkg::EV_DONE, hhfp_pkg::ERR_NONE, 16'd4},
    // halted after done
    '{"a", 1'b0, 1'b1, hhfp_pkg::EV_NONE, hhfp_pkg::ERR_NONE, 16'd5}
  };

  // One key hash round: xor the byte, multiply, xor-shift
  function automatic logic [31:0] key_mix(input logic [31:0] h, input logic [7:0] c);
    logic [31:0] m;
    m = (h ^ {24'd0, c}) * hhfp_pkg::HASH_MUL;
    return m ^ (m >> 15);
  endfunction

  // Run the rounds backward from a known hash to find the seed that produces it
  function automatic logic [31:0] seed_for(input string key, input logic [31:0] target);
    logic [31:0] inv;
    logic [31:0] h;
    inv = hhfp_pkg::HASH_MUL;
    repeat (5) inv = inv * (32'd2 - hhfp_pkg::HASH_MUL * inv);
    h = target;
    for (int i = key.len() - 1; i >= 0; i--) begin
      h = h ^ (h >> 15) ^ (h >> 30);
      h = h * inv;
      h = h ^ {24'd0, key[i]};
    end
    return h;
  endfunction

  function automatic logic [2:0] known_header(input logic [31:0] h);
    case (h)
      hhfp_pkg::HASH_HOST:   return hhfp_pkg::HDR_HOST;
      hhfp_pkg::HASH_CLEN:   return hhfp_pkg::HDR_CLEN;
      hhfp_pkg::HASH_TE:     return hhfp_pkg::HDR_TE;
      hhfp_pkg::HASH_CTYPE:  return hhfp_pkg::HDR_CTYPE;
      hhfp_pkg::HASH_CONN:   return hhfp_pkg::HDR_CONN;
      hhfp_pkg::HASH_COOKIE: return hhfp_pkg::HDR_COOKIE;
      default:               return hhfp_pkg::HDR_UNKNOWN;
    endcase
  endfunction

  function automatic logic key_char_ok(input logic [7:0] c);
    if ((c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) begin
      return 1'b1;
    end
    foreach (key_symbols[i]) begin
      if (c == key_symbols[i]) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void parser_init();
    st_phase       = PH_KEY;
    st_pos         = offset_reg;
    st_key_begin   = offset_reg;
    st_value_begin = offset_reg;
    st_trim_end    = offset_reg;
    st_hash        = seed_reg;
    st_header      = hhfp_pkg::HDR_UNKNOWN;
    st_skip        = 1'b0;
    st_empty_line  = 1'b0;
    st_extras      = '0;
    st_host_seen   = 1'b0;
    st_length_seen = 1'b0;
    st_halted      = 1'b0;
    st_other_seen  = '0;
    st_value_extra = 1'b0;
  endfunction

  // Halt the parser and give an error item
  function automatic parse_result_t halt_on(input logic [15:0] p, input logic [2:0] code);
    parse_result_t r;
    r = '0;
    r.ev = hhfp_pkg::EV_ERR;
    r.err = code;
    r.pos = p;
    st_halted = 1'b1;
    return r;
  endfunction

  // Advance the predicted parser by one byte and give the item it must answer with
  function automatic void parser_step(input logic [7:0] c_in, input logic rs,
                                      output parse_result_t r);
    logic [7:0]  c;
    logic [15:0] p;
    logic [2:0]  id;
    logic [15:0] vlen;
    logic [3:0]  bit_mask;
    logic        rep;
    c = c_in;
    r = '0;
    if (rs) begin
      parser_init();
    end
    p = st_pos;
    r.pos = p;
    if (st_halted) begin
      return;
    end
    if (p >= hhfp_pkg::BUFFER_BYTES) begin
      r = halt_on(p, hhfp_pkg::ERR_TOO_LARGE);
      return;
    end
    if (st_phase == PH_LF) begin
      if (c != hhfp_pkg::CH_LF) begin
        r = halt_on(p, hhfp_pkg::ERR_BAD_BYTE);
        return;
      end
      st_pos = p + 16'd1;
      if (st_empty_line) begin
        st_halted = 1'b1;
        r.ev = hhfp_pkg::EV_DONE;
      end else begin
        st_phase = PH_DECIDE;
      end
      return;
    end
    if (st_phase == PH_DECIDE) begin
      if (c == hhfp_pkg::CH_CR) begin
        st_empty_line = 1'b1;
        st_phase = PH_LF;
        st_pos = p + 16'd1;
        return;
      end
      st_empty_line = 1'b0;
      st_key_begin = p;
      st_hash = seed_reg;
      st_header = hhfp_pkg::HDR_UNKNOWN;
      st_phase = PH_KEY;
    end
    if (st_phase == PH_KEY) begin
      if (st_extras >= hhfp_pkg::MAX_EXTRA_HEADERS) begin
        r = halt_on(p, hhfp_pkg::ERR_TOO_LARGE);
        return;
      end
      if (c == hhfp_pkg::CH_COLON) begin
        id = known_header(st_hash);
        rep = 1'b0;
        if (id == hhfp_pkg::HDR_HOST) begin
          if (st_host_seen) begin
            r = halt_on(p, hhfp_pkg::ERR_DUPLICATE);
            return;
          end
          st_host_seen = 1'b1;
        end else if (id == hhfp_pkg::HDR_CLEN) begin
          if (st_length_seen) begin
            r = halt_on(p, hhfp_pkg::ERR_DUPLICATE);
            return;
          end
          st_length_seen = 1'b1;
        end else if (id >= hhfp_pkg::HDR_TE) begin
          // repeats of the other known headers count as extras
          bit_mask = 4'b0001 << (id - hhfp_pkg::HDR_TE);
          rep = |(st_other_seen & bit_mask);
          st_other_seen = st_other_seen | bit_mask;
        end else begin
          rep = 1'b1;
        end
        r.ev = hhfp_pkg::EV_KEY;
        r.hdr = id;
        r.hash = st_hash;
        r.fstart = st_key_begin;
        r.flen = p - st_key_begin;
        st_header = id;
        st_value_extra = rep;
        st_hash = seed_reg;
        st_skip = 1'b1;
        st_phase = PH_VALUE;
        st_pos = p + 16'd1;
        return;
      end
      if (!key_char_ok(c)) begin
        r = halt_on(p, hhfp_pkg::ERR_BAD_BYTE);
        return;
      end
      if (c >= "A" && c <= "Z") begin
        c = c + 8'd32;
      end
      st_hash = key_mix(st_hash, c);
      st_pos = p + 16'd1;
      return;
    end
    // value bytes: skip leading blanks, track the trimmed end
    if (st_skip) begin
      if (c == hhfp_pkg::CH_SPACE || c == hhfp_pkg::CH_TAB) begin
        st_pos = p + 16'd1;
        return;
      end
      st_value_begin = p;
      st_trim_end = p;
      st_skip = 1'b0;
    end
    if (c == hhfp_pkg::CH_CR) begin
      vlen = st_trim_end - st_value_begin;
      if (st_header == hhfp_pkg::HDR_HOST && vlen == 16'd0) begin
        r = halt_on(p, hhfp_pkg::ERR_EMPTY_HOST);
        return;
      end
      if (st_value_extra && st_extras < hhfp_pkg::EXTRA_COUNT_MAX) begin
        st_extras = st_extras + 8'd1;
      end
      r.ev = hhfp_pkg::EV_VALUE;
      r.hdr = st_header;
      r.fstart = st_value_begin;
      r.flen = vlen;
      st_phase = PH_LF;
      st_pos = p + 16'd1;
      return;
    end
    if (c < hhfp_pkg::CH_SPACE || c > hhfp_pkg::CH_TILDE) begin
      r = halt_on(p, hhfp_pkg::ERR_BAD_BYTE);
      return;
    end
    if (c != hhfp_pkg::CH_SPACE) begin
      st_trim_end = p + 16'd1;
    end
    st_pos = p + 16'd1;
  endfunction

  function automatic logic [7:0] pick_key_char();
    case ($urandom_range(3))
      0:       return 8'h30 + 8'($urandom_range(9));
      1:       return 8'h61 + 8'($urandom_range(25));
      2:       return 8'h41 + 8'($urandom_range(25));
      default: return key_symbols[$urandom_range(14)];
    endcase
  endfunction

  // Offer one byte item, hold it until accepted, then record its expected result item
  task automatic push_byte(input logic [7:0] b, input logic rs, input logic typed,
                           input parse_result_t typed_exp);
    parse_result_t pr;
    if (!steady && $urandom_range(99) < 22) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 30);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    restart_i   <= rs;
    do @(posedge clk_i); while (!in_ready_o);
    parser_step(b, rs, pr);
    expected_events.push_back(typed ? typed_exp : pr);
    items_sent++;
  endtask

  // Drop valid and wait until every expected result item has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
  endtask

  // Write both registers back to back, holding valid between the two writes
  task automatic apply_settings(input logic [31:0] seed, input logic [15:0] offset);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= hhfp_pkg::CFG_HASH_SEED;
    cfg_data_i  <= seed;
    do @(posedge clk_i); while (!cfg_ready_o);
    seed_reg = seed;
    cfg_index_i <= hhfp_pkg::CFG_START_OFFSET;
    cfg_data_i  <= {16'd0, offset};
    do @(posedge clk_i); while (!cfg_ready_o);
    offset_reg = offset;
    cfg_valid_i <= 1'b0;
  endtask

  // Build one request (mostly well formed, sometimes broken) and send it
  task automatic send_request(input logic flood);
    int    n;
    int    k;
    int    idx;
    string name;
    logic [7:0] ch;
    logic  is_host;
    request_bytes.delete();
    n = flood ? 36 : $urandom_range(6);
    for (int h = 0; h < n; h++) begin
      is_host = 1'b0;
      k = $urandom_range(9);
      if (flood) begin
        request_bytes.push_back(pick_key_char());
      end else if (k < 6) begin
        // known name in random case
        idx = $urandom_range(5);
        name = header_names[idx];
        is_host = (idx == 0);
        for (int j = 0; j < name.len(); j++) begin
          ch = name[j];
          if (ch >= "a" && ch <= "z" && $urandom_range(1)) begin
            ch = ch - 8'd32;
          end
          request_bytes.push_back(ch);
        end
      end else if (k < 9) begin
        repeat ($urandom_range(1, 8)) request_bytes.push_back(pick_key_char());
      end
      request_bytes.push_back(hhfp_pkg::CH_COLON);
      if (!flood) begin
        repeat ($urandom_range(2)) begin
          request_bytes.push_back($urandom_range(1) ? hhfp_pkg::CH_SPACE : hhfp_pkg::CH_TAB);
        end
        if (!(is_host && $urandom_range(3) == 0)) begin
          repeat ($urandom_range(1, 8)) request_bytes.push_back(8'($urandom_range(32, 126)));
        end
        repeat ($urandom_range(2)) request_bytes.push_back(hhfp_pkg::CH_SPACE);
      end
      request_bytes.push_back(hhfp_pkg::CH_CR);
      request_bytes.push_back(hhfp_pkg::CH_LF);
    end
    request_bytes.push_back(hhfp_pkg::CH_CR);
    request_bytes.push_back(hhfp_pkg::CH_LF);
    // break a few: a random byte anywhere, or a lost byte
    k = $urandom_range(99);
    if (k < 10) begin
      request_bytes[$urandom_range(request_bytes.size() - 1)] = 8'($urandom_range(255));
    end else if (k < 15) begin
      request_bytes.delete($urandom_range(request_bytes.size() - 1));
    end
    foreach (request_bytes[j]) begin
      push_byte(request_bytes[j], (j == 0) && ($urandom_range(9) != 0), 1'b0, '0);
    end
  endtask

  // Accept result items whenever the receiver is not stalling
  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= 22);
  end

  // Compare each accepted result item with the oldest expectation
  always @(posedge clk_i) begin
    parse_result_t got;
    parse_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{event_res_o, error_code_o, header_id_o, key_hash_o,
              field_start_o, field_len_o, position_o};
      if (expected_events.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
          $display("cycle %0d: result item with nothing expected: ev=%0d pos=%0d",
                   cycle_count, got.ev, got.pos);
        end
      end else begin
        want = expected_events.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("cycle %0d: exp ev=%0d err=%0d hdr=%0d hash=%08h start=%0d len=%0d pos=%0d",
                     cycle_count, want.ev, want.err, want.hdr, want.hash, want.fstart,
                     want.flen, want.pos);
            $display("cycle %0d: act ev=%0d err=%0d hdr=%0d hash=%08h start=%0d len=%0d pos=%0d",
                     cycle_count, got.ev, got.err, got.hdr, got.hash, got.fstart,
                     got.flen, got.pos);
          end
        end
      end
    end
  end

  // Watchdog: end a stuck run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    parse_result_t want;
    logic [31:0]   matched_seed;
    logic [31:0]   seed;
    logic [15:0]   offset;
    int            budget;
    int            stop_at;
    parser_init();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table from the reset settings
    foreach (directed_rows[i]) begin
      want = '0;
      want.ev = directed_rows[i].ev;
      want.err = directed_rows[i].err;
      want.pos = directed_rows[i].pos;
      push_byte(directed_rows[i].data, directed_rows[i].restart, directed_rows[i].typed, want);
    end
    drain_results();

    // Seed under which the known-header hashes hold
    matched_seed = seed_for("host", hhfp_pkg::HASH_HOST);

    // Random phases, each under its own settings; registers change only when idle
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       begin seed = matched_seed;  offset = 16'd0;     budget = 160; end
        1:       begin seed = 32'hffffffff;  offset = 16'hffff;  budget = 10;  end
        2:       begin seed = matched_seed;  offset = 16'd4070;  budget = 40;  end
        3:       begin seed = $urandom;      offset = 16'($urandom_range(3000)); budget = 30; end
        4:       begin seed = matched_seed;  offset = 16'($urandom_range(200));  budget = 180; end
        default: begin seed = 32'd0;         offset = 16'd0;     budget = 30;  end
      endcase
      apply_settings(seed, offset);
      // no idling on either side through one whole phase
      steady = (ph == 4);
      stop_at = items_sent + budget;
      if (ph == 0 || ph == 4) begin
        send_request(1'b1);
      end
      while (items_sent < stop_at) begin
        if ($urandom_range(99) < 10) begin
          // noise bytes, restart only at random
          for (int j = $urandom_range(1, 12); j > 0; j--) begin
            push_byte(8'($urandom_range(255)), $urandom_range(3) == 0, 1'b0, '0);
          end
        end else begin
          send_request($urandom_range(99) < 3);
        end
      end
      drain_results();
    end
    steady = 1'b0;

    // Let late or extra result items show up before the verdict
    repeat (16) @(posedge clk_i);
    if (expected_events.size() != 0) begin
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/hhfp_pkg.sv
rtl/http_header_field_parser.sv
sim/http_header_field_parser_tb.sv
